// ===== hw/rtl/adjdfs_pkg.sv =====
// Shared types and codes for the adjacency-list depth-first search engine.
// Used by adjacency_list_dfs; depends on nothing.
package adjdfs_pkg;

    // Fixed field widths
    localparam int VTX_W = 6;
    localparam int OP_W  = 2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INSERT   = 2'd0;
    localparam logic [OP_W-1:0] OP_TRAVERSE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR    = 2'd2;

    // Status codes
    localparam logic ST_OK   = 1'b0;
    localparam logic ST_DROP = 1'b1;

    // Command transfer
    typedef struct packed {
        logic [OP_W-1:0]  opcode;
        logic [VTX_W-1:0] from_vertex;
        logic [VTX_W-1:0] to_vertex;
    } t_cmd;

    // Result transfer
    typedef struct packed {
        logic             is_visit;
        logic [VTX_W-1:0] vertex;
        logic             status;
        logic             last;
    } t_result;

endpackage

// ===== hw/rtl/adjacency_list_dfs.sv =====
// Adjacency-list graph engine: edge insert, graph clear, depth-first walk.
// Insert: busy in S_INS after the transfer, status strobe as busy drops; no new command until then.
// Clear, dropped or unused command: never busy, status (none if unused) in the next cycle.
// Traverse: busy from the transfer until the walk ends, one memory read per step;
// each visit is strobed when the next is found, the last as busy drops; no receiver stall.
// Synchronous active-low reset empties all lists through head valid bits, no sweep.
module adjacency_list_dfs #(
    parameter int NUM_VERTICES = 64,
    parameter int EDGE_POOL    = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  adjdfs_pkg::t_cmd    i_cmd,
    output logic                o_strobe,
    output adjdfs_pkg::t_result o_result
);

    localparam int VW  = adjdfs_pkg::VTX_W;
    localparam int VXW = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
    localparam int DW  = $clog2(NUM_VERTICES + 1);
    localparam int AW  = $clog2(EDGE_POOL);
    localparam int EW  = $clog2(EDGE_POOL + 1);
    localparam logic [EW-1:0]   NO_EDGE = EW'(EDGE_POOL);
    localparam logic [VW:0]     NV_LIM  = (VW + 1)'(NUM_VERTICES);
    localparam logic [DW-1:0]   ONE_D   = DW'(1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_INS  = 6'b000010,
        S_HEAD = 6'b000100,
        S_TEST = 6'b001000,
        S_EDGE = 6'b010000,
        S_POP  = 6'b100000
    } t_state;

    // Memories
    logic [EW-1:0]    r_head_mem  [NUM_VERTICES];
    logic [VW+EW-1:0] r_edge_mem  [EDGE_POOL];
    logic [EW-1:0]    r_stack_mem [NUM_VERTICES];

    // Control and payload registers
    t_state              r_state, n_state;
    logic [DW-1:0]       r_depth, n_depth;
    logic [EW-1:0]       r_cur, n_cur;
    logic [EW-1:0]       r_used, n_used;
    logic [NUM_VERTICES-1:0] r_head_vld, n_head_vld;
    logic [NUM_VERTICES-1:0] r_visited, n_visited;
    logic [VW-1:0]       r_pend, n_pend;
    logic [VXW-1:0]      r_src, n_src;
    logic [VW-1:0]       r_dst, n_dst;
    logic                r_strobe, n_strobe;
    adjdfs_pkg::t_result r_result, n_result;

    // Memory read data
    logic [EW-1:0]    r_head_rd;
    logic             r_head_rd_vld;
    logic [VW+EW-1:0] r_edge_rd;
    logic [EW-1:0]    r_stack_rd;

    // Memory control
    logic [VXW-1:0] head_raddr;
    logic           head_we;
    logic           edge_re;
    logic           edge_we;
    logic           stack_re;
    logic           stack_we;
    logic [DW-1:0]  depth_m1;
    logic [DW-1:0]  depth_m2;

    logic           accept;
    logic           from_bad;
    logic           to_bad;
    logic [VW-1:0]  edge_w;
    logic [EW-1:0]  edge_nxt;
    logic [EW-1:0]  head_val;

    assign accept   = start && (r_state == S_IDLE);
    assign from_bad = {1'b0, i_cmd.from_vertex} >= NV_LIM;
    assign to_bad   = {1'b0, i_cmd.to_vertex} >= NV_LIM;
    assign edge_w   = r_edge_rd[VW+EW-1:EW];
    assign edge_nxt = r_edge_rd[EW-1:0];
    assign head_val = r_head_rd_vld ? r_head_rd : NO_EDGE;
    assign depth_m1 = r_depth - ONE_D;
    assign depth_m2 = r_depth - DW'(2);

    // Sequence commands and the walk
    always_comb begin
        n_state    = r_state;
        n_depth    = r_depth;
        n_cur      = r_cur;
        n_used     = r_used;
        n_head_vld = r_head_vld;
        n_visited  = r_visited;
        n_pend     = r_pend;
        n_src      = r_src;
        n_dst      = r_dst;
        n_strobe   = 1'b0;
        n_result   = r_result;
        head_raddr = i_cmd.from_vertex[VXW-1:0];
        head_we    = 1'b0;
        edge_re    = 1'b0;
        edge_we    = 1'b0;
        stack_re   = 1'b0;
        stack_we   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_src = i_cmd.from_vertex[VXW-1:0];
                    n_dst = i_cmd.to_vertex;
                    unique case (i_cmd.opcode)
                        adjdfs_pkg::OP_INSERT: begin
                            if (from_bad || to_bad || r_used == NO_EDGE) begin
                                n_strobe = 1'b1;
                                n_result = '{is_visit: 1'b0, vertex: '0,
                                             status: adjdfs_pkg::ST_DROP, last: 1'b1};
                            end else begin
                                n_state = S_INS;
                            end
                        end
                        adjdfs_pkg::OP_TRAVERSE: begin
                            if (from_bad) begin
                                n_strobe = 1'b1;
                                n_result = '{is_visit: 1'b0, vertex: '0,
                                             status: adjdfs_pkg::ST_DROP, last: 1'b1};
                            end else begin
                                n_visited = '0;
                                n_visited[i_cmd.from_vertex[VXW-1:0]] = 1'b1;
                                n_pend  = i_cmd.from_vertex;
                                n_depth = ONE_D;
                                n_state = S_HEAD;
                            end
                        end
                        adjdfs_pkg::OP_CLEAR: begin
                            n_head_vld = '0;
                            n_used     = '0;
                            n_strobe   = 1'b1;
                            n_result   = '{is_visit: 1'b0, vertex: '0,
                                           status: adjdfs_pkg::ST_OK, last: 1'b1};
                        end
                        default: begin
                            // unused code: drop silently
                        end
                    endcase
                end
            end
            S_INS: begin
                // link the new edge in front of the old head
                edge_we = 1'b1;
                head_we = 1'b1;
                n_head_vld[r_src] = 1'b1;
                n_used   = r_used + EW'(1);
                n_strobe = 1'b1;
                n_result = '{is_visit: 1'b0, vertex: '0,
                             status: adjdfs_pkg::ST_OK, last: 1'b1};
                n_state  = S_IDLE;
            end
            S_HEAD: begin
                n_cur   = head_val;
                n_state = S_TEST;
            end
            S_POP: begin
                n_cur   = r_stack_rd;
                n_state = S_TEST;
            end
            S_TEST: begin
                if (r_cur == NO_EDGE) begin
                    // list exhausted: pop, or finish on the bottom entry
                    n_depth = depth_m1;
                    if (r_depth == ONE_D) begin
                        n_strobe = 1'b1;
                        n_result = '{is_visit: 1'b1, vertex: r_pend,
                                     status: adjdfs_pkg::ST_OK, last: 1'b1};
                        n_state  = S_IDLE;
                    end else begin
                        stack_re = 1'b1;
                        n_state  = S_POP;
                    end
                end else begin
                    edge_re = 1'b1;
                    n_state = S_EDGE;
                end
            end
            S_EDGE: begin
                head_raddr = edge_w[VXW-1:0];
                if (!r_visited[edge_w[VXW-1:0]]) begin
                    // new vertex: save cursor, push, report the previous visit
                    stack_we = 1'b1;
                    n_depth  = r_depth + ONE_D;
                    n_visited[edge_w[VXW-1:0]] = 1'b1;
                    n_strobe = 1'b1;
                    n_result = '{is_visit: 1'b1, vertex: r_pend,
                                 status: adjdfs_pkg::ST_OK, last: 1'b0};
                    n_pend   = edge_w;
                    n_state  = S_HEAD;
                end else begin
                    n_cur   = edge_nxt;
                    n_state = S_TEST;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_depth    <= '0;
            r_used     <= '0;
            r_head_vld <= '0;
            r_visited  <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_depth    <= n_depth;
            r_used     <= n_used;
            r_head_vld <= n_head_vld;
            r_visited  <= n_visited;
            r_strobe   <= n_strobe;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cur    <= n_cur;
        r_pend   <= n_pend;
        r_src    <= n_src;
        r_dst    <= n_dst;
        r_result <= n_result;
    end

    // List head memory
    always_ff @(posedge i_clk) begin
        if (head_we) begin
            r_head_mem[r_src] <= r_used;
        end
        r_head_rd     <= r_head_mem[head_raddr];
        r_head_rd_vld <= r_head_vld[head_raddr];
    end

    // Edge pool memory: target vertex and next link
    always_ff @(posedge i_clk) begin
        if (edge_we) begin
            r_edge_mem[r_used[AW-1:0]] <= {r_dst, head_val};
        end
        if (edge_re) begin
            r_edge_rd <= r_edge_mem[r_cur[AW-1:0]];
        end
    end

    // Stack of saved edge cursors, one per entry below the top
    always_ff @(posedge i_clk) begin
        if (stack_we) begin
            r_stack_mem[depth_m1[VXW-1:0]] <= edge_nxt;
        end
        if (stack_re) begin
            r_stack_rd <= r_stack_mem[depth_m2[VXW-1:0]];
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// ===== tb/adjacency_list_dfs_tb.sv =====
// Self-checking bench for adjacency_list_dfs: directed table, then random graphs.
// Needs adjdfs_pkg and the adjacency_list_dfs RTL; reads no files.
module adjacency_list_dfs_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import adjdfs_pkg::*;

    localparam int NV            = 64;
    localparam int POOL          = 256;
    localparam logic [8:0] NO_EDGE = 9'd256;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 40;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    t_cmd    i_cmd;
    logic    o_strobe;
    t_result o_result;

    adjacency_list_dfs uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // Graph mirror: list heads, edge pool, fill count
    logic [8:0] head_of [NV];
    logic [5:0] dest_of [POOL];
    logic [8:0] link_of [POOL];
    int         pool_fill;

    t_result pending_reports [$];
    int      fault_count;
    int      quiet_cycles;

    typedef struct packed {
        t_cmd    cmd;
        logic    typed;
        t_result want;
    } t_script_row;

    localparam int SCRIPT_LEN = 25;
    t_script_row script [SCRIPT_LEN];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_cmd cmd_of(logic [OP_W-1:0] op, int src, int dst);
        t_cmd c;
        c.opcode      = op;
        c.from_vertex = src[VTX_W-1:0];
        c.to_vertex   = dst[VTX_W-1:0];
        return c;
    endfunction

    function automatic t_result res_of(logic visit, int v, logic st, logic fin);
        t_result r;
        r.is_visit = visit;
        r.vertex   = v[VTX_W-1:0];
        r.status   = st;
        r.last     = fin;
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        fault_count++;
    endtask

    task automatic empty_lists();
        for (int i = 0; i < NV; i++) head_of[i] = NO_EDGE;
        pool_fill = 0;
    endtask

    // Apply one command to the mirror and collect the results it causes
    task automatic apply_graph_cmd(input t_cmd c, output t_result outs [$]);
        bit         seen [NV];
        logic [5:0] stk_v [NV];
        logic [8:0] stk_e [NV];
        int         depth;
        int         visits;
        logic [8:0] e;
        logic [5:0] w;
        outs = {};
        case (c.opcode)
            OP_INSERT: begin
                if (pool_fill >= POOL) begin
                    outs.push_back(res_of(1'b0, 0, ST_DROP, 1'b1));
                end else begin
                    dest_of[pool_fill]     = c.to_vertex;
                    link_of[pool_fill]     = head_of[c.from_vertex];
                    head_of[c.from_vertex] = pool_fill[8:0];
                    pool_fill++;
                    outs.push_back(res_of(1'b0, 0, ST_OK, 1'b1));
                end
            end
            OP_CLEAR: begin
                empty_lists();
                outs.push_back(res_of(1'b0, 0, ST_OK, 1'b1));
            end
            OP_TRAVERSE: begin
                for (int i = 0; i < NV; i++) seen[i] = 1'b0;
                seen[c.from_vertex] = 1'b1;
                outs.push_back(res_of(1'b1, c.from_vertex, ST_OK, 1'b0));
                visits   = 1;
                stk_v[0] = c.from_vertex;
                stk_e[0] = head_of[c.from_vertex];
                depth    = 1;
                // walk newest-first; pop when the cursor runs off the list
                while (depth > 0) begin
                    e = stk_e[depth-1];
                    if (e >= NO_EDGE) begin
                        depth--;
                    end else begin
                        w = dest_of[e];
                        stk_e[depth-1] = link_of[e];
                        if (!seen[w] && visits < NV && depth < NV) begin
                            seen[w] = 1'b1;
                            outs.push_back(res_of(1'b1, w, ST_OK, 1'b0));
                            visits++;
                            stk_v[depth] = w;
                            stk_e[depth] = head_of[w];
                            depth++;
                        end
                    end
                end
                outs[outs.size()-1].last = 1'b1;
            end
            default: begin
            end
        endcase
    endtask

    // Present one command, hold it until transfer, then queue what it owes
    task automatic send_cmd(input t_cmd c, input int idle_pct, input logic typed,
                            input t_result want);
        t_result outs [$];
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
            i_cmd <= t_cmd'($urandom);
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        apply_graph_cmd(c, outs);
        if (typed) pending_reports.push_back(want);
        else foreach (outs[i]) pending_reports.push_back(outs[i]);
    endtask

    task automatic send_random(input t_cmd c, input int idle_pct);
        send_cmd(c, idle_pct, 1'b0, '0);
    endtask

    // Hold off intake until every owed result has come back
    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
    endtask

    // Mostly small vertex sets so walks go deep; a few full-range picks
    task automatic pick_cmd(output t_cmd c);
        int r;
        int span;
        r    = $urandom_range(99);
        span = ($urandom_range(3) == 0) ? NV - 1 : 7;
        c    = t_cmd'($urandom);
        if (r < 58)      c = cmd_of(OP_INSERT, $urandom_range(span), $urandom_range(span));
        else if (r < 88) c = cmd_of(OP_TRAVERSE, $urandom_range(span), $urandom_range(63));
        else if (r < 94) c.opcode = OP_CLEAR;
        else             c.opcode = OP_UNUSED;
    endtask

    task automatic run_phase(input int idle_pct, input int count);
        t_cmd c;
        int   done;
        done = 0;
        while (done < count) begin
            pick_cmd(c);
            send_random(c, idle_pct);
            if (c.opcode != OP_UNUSED) done++;
        end
    endtask

    // Check every result strobe against the oldest owed result; watch for stalls
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            if (o_strobe) begin
                if (pending_reports.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result visit=%0b v=%0d st=%0b last=%0b",
                        o_result.is_visit, o_result.vertex, o_result.status, o_result.last));
                end else begin
                    want = pending_reports.pop_front();
                    if (o_result.is_visit !== want.is_visit || o_result.vertex !== want.vertex ||
                        o_result.status !== want.status || o_result.last !== want.last)
                        flag_mismatch($sformatf(
                            "got visit=%0b v=%0d st=%0b last=%0b, want %0b %0d %0b %0b",
                            o_result.is_visit, o_result.vertex, o_result.status,
                            o_result.last, want.is_visit, want.vertex, want.status,
                            want.last));
                end
            end
            if ((start && !busy) || o_strobe) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("[%0t] watchdog: no transfer for %0d cycles", $realtime, quiet_cycles);
                $display("adjacency_list_dfs test failed");
                $finish;
            end
        end
    end

    initial begin
        fault_count = 0;
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_cmd   = '0;
        empty_lists();

        // Directed table: empty graph, extremes, self loop, duplicate, unused opcode
        script = '{
            '{cmd_of(OP_TRAVERSE, 63, 0),  1'b1, res_of(1'b1, 63, ST_OK, 1'b1)},
            '{cmd_of(OP_TRAVERSE, 0, 63),  1'b1, res_of(1'b1, 0, ST_OK, 1'b1)},
            '{cmd_of(OP_INSERT, 0, 63),    1'b1, res_of(1'b0, 0, ST_OK, 1'b1)},
            '{cmd_of(OP_INSERT, 63, 0),    1'b1, res_of(1'b0, 0, ST_OK, 1'b1)},
            '{cmd_of(OP_INSERT, 0, 0),     1'b1, res_of(1'b0, 0, ST_OK, 1'b1)},
            '{cmd_of(OP_INSERT, 0, 63),    1'b1, res_of(1'b0, 0, ST_OK, 1'b1)},
            '{cmd_of(OP_INSERT, 63, 42),   1'b1, res_of(1'b0, 0, ST_OK, 1'b1)},
            '{cmd_of(OP_INSERT, 42, 21),   1'b1, res_of(1'b0, 0, ST_OK, 1'b1)},
            '{cmd_of(OP_INSERT, 21, 0),    1'b1, res_of(1'b0, 0, ST_OK, 1'b1)},
            '{cmd_of(OP_TRAVERSE, 0, 0),   1'b0, '0},
            '{cmd_of(OP_TRAVERSE, 63, 0),  1'b0, '0},
            '{cmd_of(OP_TRAVERSE, 21, 63), 1'b0, '0},
            '{cmd_of(OP_UNUSED, 63, 63),   1'b0, '0},
            '{cmd_of(OP_UNUSED, 0, 0),     1'b0, '0},
            '{cmd_of(OP_TRAVERSE, 42, 0),  1'b0, '0},
            '{cmd_of(OP_CLEAR, 63, 63),    1'b1, res_of(1'b0, 0, ST_OK, 1'b1)},
            '{cmd_of(OP_TRAVERSE, 0, 0),   1'b1, res_of(1'b1, 0, ST_OK, 1'b1)},
            '{cmd_of(OP_INSERT, 1, 2),     1'b1, res_of(1'b0, 0, ST_OK, 1'b1)},
            '{cmd_of(OP_INSERT, 2, 4),     1'b1, res_of(1'b0, 0, ST_OK, 1'b1)},
            '{cmd_of(OP_INSERT, 4, 8),     1'b1, res_of(1'b0, 0, ST_OK, 1'b1)},
            '{cmd_of(OP_INSERT, 8, 16),    1'b1, res_of(1'b0, 0, ST_OK, 1'b1)},
            '{cmd_of(OP_INSERT, 16, 32),   1'b1, res_of(1'b0, 0, ST_OK, 1'b1)},
            '{cmd_of(OP_INSERT, 32, 1),    1'b1, res_of(1'b0, 0, ST_OK, 1'b1)},
            '{cmd_of(OP_TRAVERSE, 1, 0),   1'b0, '0},
            '{cmd_of(OP_CLEAR, 0, 0),      1'b1, res_of(1'b0, 0, ST_OK, 1'b1)}
        };

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i]) send_cmd(script[i].cmd, 15, script[i].typed, script[i].want);
        drain_results();

        // Light sender idling
        run_phase(15, 45);

        // Walk the graph the random phase left behind, then empty it
        repeat (4) send_random(cmd_of(OP_TRAVERSE, $urandom_range(7), 0), 15);
        send_random(cmd_of(OP_CLEAR, 0, 0), 15);
        drain_results();

        // Heavy sender idling, then back to back
        run_phase(73, 45);
        drain_results();
        run_phase(0, 45);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fault_count == 0)
            $display("adjacency_list_dfs test passed");
        else
            $display("adjacency_list_dfs test failed");
        $finish;
    end

endmodule
